@@ hdl/mrf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mrf_pkg;

    localparam int MAX_DIM = 16;
    localparam int ELEM_W  = 32;
    localparam int DIM_W   = 5;
    localparam int POS_W   = 4;
    localparam int ADDR_W  = 8;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int CMD_W   = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int TDATA_W = 48;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ROTATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLIP   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

    localparam logic REG_LOAD_ROWS = 1'b0;
    localparam logic REG_LOAD_COLS = 1'b1;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ELEM_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_store_req;

endpackage

`default_nettype wire

@@ hdl/mrf_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mrf_store
    import mrf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_store_req        i_req,
    output logic [ELEM_W-1:0]      o_rd_data
);

    logic [ELEM_W-1:0] r_mem [DEPTH];
    logic [ELEM_W-1:0] r_rd_data;

    // one write port, one read port; read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ hdl/matrix_rotate_flip_undo_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                  Contents
// s_axis    in   tvalid/tready              tdata: element_in; tuser: command
// m_axis    out  tvalid/tready              tdata: element_out, rows_now, cols_now;
//                                           tuser: row_end; tlast: last_element
// apb       in   psel/penable/pwrite/pready reg 0 load_rows @0x0, reg 1 load_cols @0x4
//
// A beat can be accepted on every clock edge unless a stall on m_axis holds s_axis_tready low.
// A read beat reaches m_axis through the store read register, which the read stage
// tracks, and then through the output register.
// Reset is synchronous and clears control state; the element store is not cleared.
// A stall on m_axis fills the read stage, then drops s_axis_tready until it drains.

module matrix_rotate_flip_undo_core
    import mrf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [ELEM_W-1:0]  s_axis_tdata,   // [31:0] element_in
    input  wire logic [CMD_W-1:0]   s_axis_tuser,   // [1:0] command

    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata,   // [31:0] element_out, [36:32] rows_now,
                                                    // [41:37] cols_now, [47:42] zero
    output logic                    m_axis_tuser,   // [0] row_end
    output logic                    m_axis_tlast,   // last_element

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]  r_load_rows, n_load_rows;
    logic [DIM_W-1:0]  r_load_cols, n_load_cols;
    logic [DIM_W-1:0]  r_cur_rows,  n_cur_rows;
    logic [DIM_W-1:0]  r_cur_cols,  n_cur_cols;
    logic [2:0]        r_orient,    n_orient;   // bit0 transposed, bit1 rev row, bit2 rev col
    logic [ADDR_W-1:0] r_wr_ptr,    n_wr_ptr;
    logic [POS_W-1:0]  r_rd_row,    n_rd_row;
    logic [POS_W-1:0]  r_rd_col,    n_rd_col;

    // read stage: store read in flight, metadata travels alongside
    logic              r_s1_valid;
    logic [DIM_W-1:0]  r_s1_rows;
    logic [DIM_W-1:0]  r_s1_cols;
    logic              r_s1_row_end;
    logic              r_s1_last;

    // output register
    logic              r_out_valid;
    logic [ELEM_W-1:0] r_out_elem;
    logic [DIM_W-1:0]  r_out_rows;
    logic [DIM_W-1:0]  r_out_cols;
    logic              r_out_row_end;
    logic              r_out_last;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic out_ready, s1_adv, in_acc, cfg_wr, rd_acc;

    assign out_ready     = !r_out_valid || m_axis_tready;
    assign s1_adv        = !r_s1_valid || out_ready;
    assign s_axis_tready = s1_adv;
    assign in_acc        = s_axis_tvalid && s1_adv;
    assign rd_acc        = in_acc && (s_axis_tuser == CMD_READ);
    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite;

    // ------------------------------------------------------------------
    // Read address: map current position back to the loaded layout
    // ------------------------------------------------------------------
    logic [POS_W-1:0]       pos_p, pos_q, p_cl, q_cl, idx_a, idx_b;
    logic [DIM_W-1:0]       lr_m1, lc_m1;
    logic [DIM_W+POS_W-1:0] row_base;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   row_end, last_elem;
    logic [DIM_W-1:0]       col_nx, row_nx;

    always_comb begin
        pos_p    = r_orient[0] ? r_rd_col : r_rd_row;
        pos_q    = r_orient[0] ? r_rd_row : r_rd_col;
        lr_m1    = r_load_rows - 5'd1;
        lc_m1    = r_load_cols - 5'd1;
        // clamp the mapped position into the loaded matrix
        p_cl     = ({1'b0, pos_p} >= r_load_rows) ? lr_m1[POS_W-1:0] : pos_p;
        q_cl     = ({1'b0, pos_q} >= r_load_cols) ? lc_m1[POS_W-1:0] : pos_q;
        idx_a    = r_orient[1] ? (lr_m1[POS_W-1:0] - p_cl) : p_cl;
        idx_b    = r_orient[2] ? (lc_m1[POS_W-1:0] - q_cl) : q_cl;
        row_base = {{DIM_W{1'b0}}, idx_a} * {{POS_W{1'b0}}, r_load_cols};
        rd_addr  = row_base[ADDR_W-1:0] + {{(ADDR_W-POS_W){1'b0}}, idx_b};

        col_nx    = {1'b0, r_rd_col} + 5'd1;
        row_nx    = {1'b0, r_rd_row} + 5'd1;
        row_end   = (col_nx >= r_cur_cols);
        last_elem = row_end && (row_nx >= r_cur_rows);
    end

    // ------------------------------------------------------------------
    // Configuration value: keep the low five bits, saturate into 1..MAX_DIM
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] cfg_dim;

    always_comb begin
        if (pwdata[DIM_W-1:0] == '0) begin
            cfg_dim = 5'd1;
        end else if (pwdata[DIM_W-1:0] > DIM_W'(MAX_DIM)) begin
            cfg_dim = DIM_W'(MAX_DIM);
        end else begin
            cfg_dim = pwdata[DIM_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_LOAD_ROWS: prdata = {{(PDATA_W-DIM_W){1'b0}}, r_load_rows};
            REG_LOAD_COLS: prdata = {{(PDATA_W-DIM_W){1'b0}}, r_load_cols};
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Command sequencer
    // ------------------------------------------------------------------
    logic [ADDR_W:0]  wr_ptr_nx;
    logic [ADDR_W:0]  total;
    t_store_req       store_req;

    always_comb begin
        n_load_rows = r_load_rows;
        n_load_cols = r_load_cols;
        n_cur_rows  = r_cur_rows;
        n_cur_cols  = r_cur_cols;
        n_orient    = r_orient;
        n_wr_ptr    = r_wr_ptr;
        n_rd_row    = r_rd_row;
        n_rd_col    = r_rd_col;

        total     = {{(ADDR_W+1-DIM_W){1'b0}}, r_load_rows} *
                    {{(ADDR_W+1-DIM_W){1'b0}}, r_load_cols};
        wr_ptr_nx = {1'b0, r_wr_ptr} + 9'd1;

        store_req.wr_en   = in_acc && (s_axis_tuser == CMD_LOAD);
        store_req.wr_addr = r_wr_ptr;
        store_req.wr_data = s_axis_tdata;
        store_req.rd_en   = rd_acc;
        store_req.rd_addr = rd_addr;

        if (cfg_wr) begin
            // a register write restarts the transform; the store keeps its contents
            if (paddr[2] == REG_LOAD_COLS) begin
                n_load_cols = cfg_dim;
                n_cur_cols  = cfg_dim;
                n_cur_rows  = r_load_rows;
            end else begin
                n_load_rows = cfg_dim;
                n_cur_rows  = cfg_dim;
                n_cur_cols  = r_load_cols;
            end
            n_orient = '0;
            n_wr_ptr = '0;
            n_rd_row = '0;
            n_rd_col = '0;
        end else if (in_acc) begin
            case (s_axis_tuser)
                CMD_LOAD: begin
                    // wrap to the start after the last loaded element
                    n_wr_ptr = (wr_ptr_nx >= total) ? '0 : wr_ptr_nx[ADDR_W-1:0];
                end
                CMD_ROTATE: begin
                    n_orient   = r_orient[0] ? (r_orient ^ 3'b011) : (r_orient ^ 3'b101);
                    n_cur_rows = r_cur_cols;
                    n_cur_cols = r_cur_rows;
                    n_rd_row   = '0;
                    n_rd_col   = '0;
                end
                CMD_FLIP: begin
                    n_orient = r_orient[0] ? (r_orient ^ 3'b100) : (r_orient ^ 3'b010);
                    n_rd_row = '0;
                    n_rd_col = '0;
                end
                default: begin
                    // read: advance the position, wrap after the last element
                    if (last_elem) begin
                        n_rd_row = '0;
                        n_rd_col = '0;
                    end else if (row_end) begin
                        n_rd_row = row_nx[POS_W-1:0];
                        n_rd_col = '0;
                    end else begin
                        n_rd_col = col_nx[POS_W-1:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_rows <= 5'd1;
            r_load_cols <= 5'd1;
            r_cur_rows  <= 5'd1;
            r_cur_cols  <= 5'd1;
            r_orient    <= '0;
            r_wr_ptr    <= '0;
            r_rd_row    <= '0;
            r_rd_col    <= '0;
        end else begin
            r_load_rows <= n_load_rows;
            r_load_cols <= n_load_cols;
            r_cur_rows  <= n_cur_rows;
            r_cur_cols  <= n_cur_cols;
            r_orient    <= n_orient;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_row    <= n_rd_row;
            r_rd_col    <= n_rd_col;
        end
    end

    // ------------------------------------------------------------------
    // Element store
    // ------------------------------------------------------------------
    logic [ELEM_W-1:0] store_rd_data;

    mrf_store u_store (
        .i_clk     (i_clk),
        .i_req     (store_req),
        .o_rd_data (store_rd_data)
    );

    // ------------------------------------------------------------------
    // Read stage and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= rd_acc;
            end
            if (out_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_acc) begin
            r_s1_rows    <= r_cur_rows;
            r_s1_cols    <= r_cur_cols;
            r_s1_row_end <= row_end;
            r_s1_last    <= last_elem;
        end
        // the store read data holds while the read stage waits
        if (out_ready && r_s1_valid) begin
            r_out_elem    <= store_rd_data;
            r_out_rows    <= r_s1_rows;
            r_out_cols    <= r_s1_cols;
            r_out_row_end <= r_s1_row_end;
            r_out_last    <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(TDATA_W-ELEM_W-2*DIM_W){1'b0}}, r_out_cols, r_out_rows, r_out_elem};
    assign m_axis_tuser  = r_out_row_end;
    assign m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !m_axis_tready |=> r_s1_valid)
        else $error("read stage dropped a beat while output stalled");

    a_read_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_acc |=> r_s1_valid)
        else $error("accepted read did not enter the read stage");

    a_last_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |-> r_out_row_end)
        else $error("last element without row end");

    a_dims_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_rows >= 5'd1 && r_cur_rows <= DIM_W'(MAX_DIM) &&
        r_cur_cols >= 5'd1 && r_cur_cols <= DIM_W'(MAX_DIM))
        else $error("current size out of range");

    a_wr_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_wr_ptr} < total)
        else $error("write pointer past loaded matrix");

endmodule

`default_nettype wire
